### rtl/heap_sort_engine_assert.svh
// Assertion macros for the heap sort engine.
// Each expects clk and rst_n in the scope of the module that uses it.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define HSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hse_pkg.sv
package hse_pkg;

    // Read address source of the key memory
    typedef enum logic [2:0] {
        RD_LEFT  = 3'd0,
        RD_RIGHT = 3'd1,
        RD_ROOT  = 3'd2,
        RD_TAIL  = 3'd3,
        RD_EMIT  = 3'd4
    } rd_src_t;

    // Write source of the key memory
    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_LOAD = 3'd1,
        WR_CAND = 3'd2,
        WR_KEY  = 3'd3,
        WR_TAIL = 3'd4
    } wr_src_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;        // store incoming key, bump count
        logic    set_build;   // heap size = count, iterator = count / 2
        logic    next_build;  // sift node = iterator - 1, iterator down
        logic    set_sort;    // iterator = count
        logic    cap_key;     // take read data as the key being sifted
        logic    cap_left;    // take read data as the left child
        logic    cap_root;    // take read data as the current root
        logic    emit_init;   // restart the emit pointer
        logic    out_load;    // move read data into the output register
        rd_src_t rd_src;
        wr_src_t wr_src;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;        // next stored key fills the memory
        logic left_ok;     // sift node has a left child inside the heap
        logic do_swap;     // larger child beats the sifted key
        logic iter_zero;
        logic iter_le1;
        logic emit_last;   // emit pointer is on the final key
        logic out_free;    // output register empty by the next edge
    } status_t;

endpackage

### rtl/hse_datapath.sv
module hse_datapath #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hse_pkg::cmd_t      cmd,
    output hse_pkg::status_t   status,
    input  logic signed [31:0] key,
    output logic signed [31:0] sorted_key,
    output logic               end_of_set,
    output logic               out_valid,
    input  logic               out_stall
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CHW = AW + 2;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] heap_end_reg, heap_end_next;
    logic [CW-1:0] iter_reg, iter_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] emit_reg, emit_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   best_reg, best_next;
    logic          right_ok_reg, right_ok_next;
    logic [31:0]   out_key_reg, out_key_next;
    logic          out_eos_reg, out_eos_next;
    logic          out_vld_reg, out_vld_next;

    logic [CHW-1:0] left_idx;
    logic [CHW-1:0] right_idx;
    logic [CHW-1:0] heap_end_ext;
    logic [CW-1:0]  iter_m1;
    logic [CW-1:0]  count_m1;
    logic           pick_right;
    logic [31:0]    cand_val;
    logic [AW-1:0]  cand_idx;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [31:0]    wr_data;
    logic           out_fire;

    // Child indices and comparisons
    assign left_idx     = {1'b0, node_reg, 1'b1};
    assign right_idx    = left_idx + CHW'(1);
    assign heap_end_ext = {{(CHW - CW){1'b0}}, heap_end_reg};
    assign iter_m1      = iter_reg - CW'(1);
    assign count_m1     = count_reg - CW'(1);
    assign pick_right   = right_ok_reg && ($signed(rdata_reg) > $signed(best_reg));
    assign cand_val     = pick_right ? rdata_reg : best_reg;
    assign cand_idx     = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign out_fire     = out_vld_reg && !out_stall;

    // Report status
    always_comb
    begin
        status.full      = (count_reg == CW'(DEPTH - 1));
        status.left_ok   = (left_idx < heap_end_ext);
        status.do_swap   = ($signed(cand_val) > $signed(key_reg));
        status.iter_zero = (iter_reg == '0);
        status.iter_le1  = (iter_reg <= CW'(1));
        status.emit_last = (CW'(emit_reg) == count_m1);
        status.out_free  = !out_vld_reg || out_fire;
    end

    // Select the read address
    always_comb
    begin
        case (cmd.rd_src)
            hse_pkg::RD_LEFT:  rd_addr = left_idx[AW-1:0];
            hse_pkg::RD_RIGHT: rd_addr = right_idx[AW-1:0];
            hse_pkg::RD_ROOT:  rd_addr = '0;
            hse_pkg::RD_TAIL:  rd_addr = iter_m1[AW-1:0];
            hse_pkg::RD_EMIT:  rd_addr = emit_reg;
            default:           rd_addr = '0;
        endcase
    end

    // Select the write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = node_reg;
        wr_data = key_reg;
        unique case (cmd.wr_src)
            hse_pkg::WR_LOAD:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = key;
            end
            hse_pkg::WR_CAND:
            begin
                wr_data = cand_val;
            end
            hse_pkg::WR_KEY:
            begin
                wr_data = key_reg;
            end
            hse_pkg::WR_TAIL:
            begin
                wr_addr = iter_m1[AW-1:0];
                wr_data = best_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Key memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Next values of counters and working registers
    always_comb
    begin
        count_next    = count_reg;
        heap_end_next = heap_end_reg;
        iter_next     = iter_reg;
        node_next     = node_reg;
        emit_next     = emit_reg;
        key_next      = key_reg;
        best_next     = best_reg;
        right_ok_next = right_ok_reg;
        out_key_next  = out_key_reg;
        out_eos_next  = out_eos_reg;
        out_vld_next  = out_fire ? 1'b0 : out_vld_reg;

        if (cmd.load)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_build)
        begin
            heap_end_next = count_reg;
            iter_next     = count_reg >> 1;
        end
        if (cmd.next_build)
        begin
            node_next = iter_m1[AW-1:0];
            iter_next = iter_m1;
        end
        if (cmd.set_sort)
        begin
            iter_next = count_reg;
        end
        if (cmd.cap_key)
        begin
            key_next = rdata_reg;
        end
        if (cmd.cap_left)
        begin
            best_next     = rdata_reg;
            right_ok_next = (right_idx < heap_end_ext);
        end
        if (cmd.cap_root)
        begin
            best_next = rdata_reg;
        end
        // Swap root with the heap tail: tail value becomes the sifted key
        if (cmd.wr_src == hse_pkg::WR_TAIL)
        begin
            key_next      = rdata_reg;
            heap_end_next = iter_m1;
            iter_next     = iter_m1;
            node_next     = '0;
        end
        // Move the larger child up and follow it down
        if (cmd.wr_src == hse_pkg::WR_CAND)
        begin
            node_next = cand_idx;
        end
        if (cmd.emit_init)
        begin
            emit_next = '0;
        end
        if (cmd.out_load)
        begin
            out_key_next = rdata_reg;
            out_eos_next = status.emit_last;
            out_vld_next = 1'b1;
            emit_next    = emit_reg + AW'(1);
            if (status.emit_last)
            begin
                count_next = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            heap_end_reg <= '0;
            iter_reg     <= '0;
            node_reg     <= '0;
            emit_reg     <= '0;
            right_ok_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            heap_end_reg <= heap_end_next;
            iter_reg     <= iter_next;
            node_reg     <= node_next;
            emit_reg     <= emit_next;
            right_ok_reg <= right_ok_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        best_reg    <= best_next;
        out_key_reg <= out_key_next;
        out_eos_reg <= out_eos_next;
    end

    assign sorted_key = $signed(out_key_reg);
    assign end_of_set = out_eos_reg;
    assign out_valid  = out_vld_reg;

endmodule

### rtl/hse_ctrl.sv
module hse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last,
    input  hse_pkg::status_t status,
    output logic             in_stall,
    output hse_pkg::cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_LOAD       = 12'b0000_0000_0001,
        ST_SETUP      = 12'b0000_0000_0010,
        ST_BUILD_NEXT = 12'b0000_0000_0100,
        ST_SORT_NEXT  = 12'b0000_0000_1000,
        ST_SORT_TAIL  = 12'b0000_0001_0000,
        ST_SORT_SWAP  = 12'b0000_0010_0000,
        ST_KEY_CAP    = 12'b0000_0100_0000,
        ST_LEFT       = 12'b0000_1000_0000,
        ST_RIGHT      = 12'b0001_0000_0000,
        ST_CMP        = 12'b0010_0000_0000,
        ST_EMIT_RD    = 12'b0100_0000_0000,
        ST_EMIT_LD    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   sorting_reg, sorting_next;
    state_t sift_done;

    assign in_stall  = (state_reg != ST_LOAD);
    assign sift_done = sorting_reg ? ST_SORT_NEXT : ST_BUILD_NEXT;

    // Sequence load, heap build, sort-down and emit
    always_comb
    begin
        state_next   = state_reg;
        sorting_next = sorting_reg;
        cmd          = '0;
        cmd.rd_src   = hse_pkg::RD_LEFT;
        cmd.wr_src   = hse_pkg::WR_NONE;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.wr_src = hse_pkg::WR_LOAD;
                    if (last || status.full)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.set_build = 1'b1;
                sorting_next  = 1'b0;
                state_next    = ST_BUILD_NEXT;
            end
            ST_BUILD_NEXT:
            begin
                if (status.iter_zero)
                begin
                    cmd.set_sort = 1'b1;
                    sorting_next = 1'b1;
                    state_next   = ST_SORT_NEXT;
                end
                else
                begin
                    cmd.next_build = 1'b1;
                    cmd.rd_src     = hse_pkg::RD_TAIL;
                    state_next     = ST_KEY_CAP;
                end
            end
            ST_SORT_NEXT:
            begin
                if (status.iter_le1)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    cmd.rd_src = hse_pkg::RD_ROOT;
                    state_next = ST_SORT_TAIL;
                end
            end
            ST_SORT_TAIL:
            begin
                cmd.cap_root = 1'b1;
                cmd.rd_src   = hse_pkg::RD_TAIL;
                state_next   = ST_SORT_SWAP;
            end
            ST_SORT_SWAP:
            begin
                cmd.wr_src = hse_pkg::WR_TAIL;
                state_next = ST_LEFT;
            end
            ST_KEY_CAP:
            begin
                cmd.cap_key = 1'b1;
                state_next  = ST_LEFT;
            end
            ST_LEFT:
            begin
                if (status.left_ok)
                begin
                    cmd.rd_src = hse_pkg::RD_LEFT;
                    state_next = ST_RIGHT;
                end
                else
                begin
                    cmd.wr_src = hse_pkg::WR_KEY;
                    state_next = sift_done;
                end
            end
            ST_RIGHT:
            begin
                cmd.cap_left = 1'b1;
                cmd.rd_src   = hse_pkg::RD_RIGHT;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.do_swap)
                begin
                    cmd.wr_src = hse_pkg::WR_CAND;
                    state_next = ST_LEFT;
                end
                else
                begin
                    cmd.wr_src = hse_pkg::WR_KEY;
                    state_next = sift_done;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_src = hse_pkg::RD_EMIT;
                if (status.out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = status.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sorting_reg <= sorting_next;
        end
    end

endmodule

### rtl/heap_sort_engine.sv
// Loading takes one request per cycle; the request that ends a set (last, or DEPTH keys)
// starts sorting on a single-read-port key memory: a sift level reads both children, then
// compares and writes; a sift ends by writing its key; a build sift first reads its key, and
// a root swap reads the root and the tail, then swaps them. Emitting loads each key once the
// output register is free, then loading resumes while the final key waits to be taken.
// Reset clears controller, counters and output valid; the key memory is written before read.
module heap_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] key,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sorted_key,
    output logic               end_of_set
);

    `include "heap_sort_engine_assert.svh"

    hse_pkg::cmd_t    cmd;
    hse_pkg::status_t status;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    hse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key        (key),
        .sorted_key (sorted_key),
        .end_of_set (end_of_set),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    // A request that ends a set stops further loading until the set is emitted
    `HSE_ASSERT_NEXT(a_set_end_stalls, cmd.load && (last || status.full), in_stall,
                     "load continued after set end")

    // Loading resumes right after the final key enters the output register
    `HSE_ASSERT_NEXT(a_emit_end_loads, cmd.out_load && status.emit_last, !in_stall,
                     "no return to loading")

    // A child moves up only after the left child was found inside the heap
    `HSE_ASSERT_SAME(a_swap_has_child, cmd.wr_src == hse_pkg::WR_CAND,
                     $past(status.left_ok, 2), "swap without child")

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_DEPTH = 64;
    localparam int MAX_GAP = 13;
    localparam int LIMIT_NS = 5_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [31:0] key;
        logic        end_of_set;
    } sorted_entry_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] key;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] sorted_key;
    logic               end_of_set;

    // keys of the set being loaded, and the sorted keys still to come out
    logic signed [31:0] set_keys [SET_DEPTH];
    int                 set_count = 0;
    sorted_entry_t      sorted_queue [$];

    int mismatches = 0;
    int requests_sent = 0;
    bit idle_send = 1'b1;
    bit idle_recv = 1'b1;
    int recv_wait = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    heap_sort_engine #(
        .DEPTH(SET_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .key(key),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_key(sorted_key),
        .end_of_set(end_of_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(LIMIT_NS);
        $display("** heap_sort_engine: FAILED **");
        $finish;
    end

    // Add one accepted key; once the set ends, sort it and queue its results
    task automatic take_key(input logic signed [31:0] k, input logic l);
        logic signed [31:0] v;
        int i;
        int j;
        set_keys[set_count] = k;
        set_count++;
        if (l || set_count == SET_DEPTH)
        begin
            for (i = 1; i < set_count; i++)
            begin
                v = set_keys[i];
                j = i - 1;
                while (j >= 0 && set_keys[j] > v)
                begin
                    set_keys[j + 1] = set_keys[j];
                    j--;
                end
                set_keys[j + 1] = v;
            end
            for (i = 0; i < set_count; i++)
                sorted_queue.push_back({set_keys[i], i == set_count - 1});
            set_count = 0;
        end
    endtask

    // Track every accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            take_key(key, last);
    end

    // Compare each accepted result against the oldest expected key
    always @(posedge clk)
    begin
        sorted_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sorted_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got key %0d end_of_set %0b",
                         $time, sorted_key, end_of_set);
                mismatches++;
            end
            else
            begin
                want = sorted_queue.pop_front();
                if (want.key !== sorted_key)
                begin
                    $display("%0t: sorted_key mismatch, expected %0d, got %0d",
                             $time, $signed(want.key), sorted_key);
                    mismatches++;
                end
                if (want.end_of_set !== end_of_set)
                begin
                    $display("%0t: end_of_set mismatch, expected %0b, got %0b",
                             $time, want.end_of_set, end_of_set);
                    mismatches++;
                end
            end
            recv_wait = idle_recv ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    // Drive the output stall: long hold-offs first, then per-result waits
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one request after a random gap (none unless idle_send) and hold it until accepted
    task automatic send_key(input logic signed [31:0] k, input logic l);
        int gap;
        gap = idle_send ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        key <= k;
        last <= l;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // Drop valid before any pause
    task automatic drop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sorted_queue.size() != 0)
            @(posedge clk);
    endtask

    // Mix full-range keys with a narrow band (duplicates) and the extremes
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 7)) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Send a set of random keys; mark the final one only if asked
    task automatic send_set(input int n, input logic mark_last);
        int i;
        for (i = 0; i < n; i++)
            send_key(pick_key(), (i == n - 1) ? mark_last : 1'b0);
    endtask

    task automatic test_single_keys();
        send_key(32'h8000_0000, 1'b1);
        send_key(32'h7fff_ffff, 1'b1);
        send_key(32'h0000_0000, 1'b1);
        send_key(32'hffff_ffff, 1'b1);
    endtask

    task automatic test_extreme_keys();
        send_key(32'h7fff_ffff, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'hffff_ffff, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h5555_5555, 1'b0);
        send_key(32'haaaa_aaaa, 1'b0);
        send_key(32'h7fff_fffe, 1'b0);
        send_key(32'h8000_0001, 1'b1);
    endtask

    task automatic test_equal_keys();
        send_key(5, 1'b0);
        send_key(-3, 1'b0);
        send_key(5, 1'b0);
        send_key(5, 1'b0);
        send_key(-3, 1'b0);
        send_key(7, 1'b0);
        send_key(7, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h8000_0000, 1'b1);
    endtask

    // A full store ends the set without last; the next set starts from empty
    task automatic test_full_store();
        send_set(SET_DEPTH, 1'b0);
        send_set(2, 1'b1);
    endtask

    task automatic test_random_sets();
        int n;
        int start;
        start = requests_sent;
        while (requests_sent - start < 150)
        begin
            idle_send = $urandom_range(0, 2) != 0;
            idle_recv = $urandom_range(0, 2) != 0;
            n = ($urandom_range(0, 11) == 0) ? SET_DEPTH : $urandom_range(1, 12);
            send_set(n, (n == SET_DEPTH) ? 1'($urandom_range(0, 1)) : 1'b1);
        end
        idle_send = 1'b1;
        idle_recv = 1'b1;
    endtask

    // Hold off the output while requests keep coming, so the input backs up
    task automatic test_output_hold();
        idle_send = 1'b0;
        hold_len = 600;
        hold_seq++;
        send_set(8, 1'b1);
        send_set(8, 1'b1);
        send_set(8, 1'b1);
        idle_send = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        send_set(6, 1'b1);
        drop_input();
        wait_drained();
        send_set(5, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        key = '0;
        last = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_keys();
        test_extreme_keys();
        test_equal_keys();
        test_full_store();
        test_random_sets();
        test_output_hold();
        test_pause_until_drained();

        // Let the last results come out, then settle
        drop_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && sorted_queue.size() == 0)
            $display("** heap_sort_engine: PASSED **");
        else
            $display("** heap_sort_engine: FAILED **");
        $finish;
    end
endmodule
